FILE: rtl/core/rldr_pkg.sv
`default_nettype none

package rldr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int SIZE_W     = 10;
  localparam int COEF_W     = 18;
  localparam int INVN_W     = 16;
  localparam int COORD_W    = 9;
  localparam int PIX_W      = 8;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [SIZE_W-1:0]     size_t;
  typedef logic [COORD_W-1:0]    coord_t;
  typedef logic [PIX_W-1:0]      pix_t;

  localparam cfg_idx_t CFG_ROWS_IN_USE = 3'd0;
  localparam cfg_idx_t CFG_COLS_IN_USE = 3'd1;
  localparam cfg_idx_t CFG_K_FIRST     = 3'd2;
  localparam cfg_idx_t CFG_K_SECOND    = 3'd3;
  localparam cfg_idx_t CFG_INV_NORM_SQ = 3'd4;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  localparam size_t                     RST_ROWS  = 10'd512;
  localparam size_t                     RST_COLS  = 10'd512;
  localparam logic signed [COEF_W-1:0]  RST_K1    = -18'sd23174;
  localparam logic signed [COEF_W-1:0]  RST_K2    = 18'sd11338;
  localparam logic        [INVN_W-1:0]  RST_INVN  = 16'd11930;

  // remap pipeline depth from accept to the memory access
  localparam int PIPE_DEPTH = 8;

endpackage

`default_nettype wire

FILE: rtl/core/radial_lens_distortion_remap.sv
`default_nettype none

// Radial lens distortion remap over a single-plane frame store.
// A request is taken at a rising edge with start high and busy low. A write
// request (in_mode 0) stores in_pixel_in at (in_row, in_col); writes outside
// the store are dropped and give no result. A read request (in_mode 1)
// computes the two-term radial source coordinate and answers with the stored
// pixel there plus the clamped source row and column.
// Results appear on out_* for one cycle with out_valid high; they cannot be
// held off. Requests of either kind are accepted every cycle while busy is
// low: the multiplier chain (eight register stages) runs ahead of the single
// frame memory port, and writes travel the same stages so memory accesses
// stay in request order. The user must write registers through cfg_we/
// cfg_index/cfg_wdata only while no read is in flight; the block does not
// enforce it. Reset loads the register defaults, empties the pipeline and
// holds busy high until the first clock edge after reset is released; the
// frame store is not cleared and must be written before it is read.

module radial_lens_distortion_remap #(
  parameter int MAX_ROWS = 512,
  parameter int MAX_COLS = 512
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire                  in_mode,
  input  wire rldr_pkg::coord_t in_row,
  input  wire rldr_pkg::coord_t in_col,
  input  wire rldr_pkg::pix_t   in_pixel_in,
  output logic                 out_valid,
  output rldr_pkg::pix_t       out_pixel_out,
  output rldr_pkg::coord_t     out_src_row,
  output rldr_pkg::coord_t     out_src_col,
  input  wire                  cfg_we,
  input  wire rldr_pkg::cfg_idx_t  cfg_index,
  input  wire rldr_pkg::cfg_data_t cfg_wdata
);
  import rldr_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  typedef logic [AW-1:0] addr_t;

  // configuration
  size_t                    rows_r, cols_r;
  logic signed [COEF_W-1:0] k1_r, k2_r;
  logic [INVN_W-1:0]        invn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= RST_ROWS;
      cols_r <= RST_COLS;
      k1_r   <= RST_K1;
      k2_r   <= RST_K2;
      invn_r <= RST_INVN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS_IN_USE: rows_r <= cfg_wdata[SIZE_W-1:0];
        CFG_COLS_IN_USE: cols_r <= cfg_wdata[SIZE_W-1:0];
        CFG_K_FIRST:     k1_r   <= cfg_wdata[COEF_W-1:0];
        CFG_K_SECOND:    k2_r   <= cfg_wdata[COEF_W-1:0];
        CFG_INV_NORM_SQ: invn_r <= cfg_wdata[INVN_W-1:0];
        default: ;
      endcase
    end
  end

  // frame size in use, saturated to 1..MAX
  size_t h_used, w_used, h_m1, w_m1;
  coord_t ch, cw;

  always_comb begin
    if (rows_r == '0) begin
      h_used = size_t'(1);
    end else if (13'(rows_r) > 13'(MAX_ROWS)) begin
      h_used = size_t'(MAX_ROWS);
    end else begin
      h_used = rows_r;
    end
    if (cols_r == '0) begin
      w_used = size_t'(1);
    end else if (13'(cols_r) > 13'(MAX_COLS)) begin
      w_used = size_t'(MAX_COLS);
    end else begin
      w_used = cols_r;
    end
    h_m1 = h_used - size_t'(1);
    w_m1 = w_used - size_t'(1);
    ch   = h_used[SIZE_W-1:1];
    cw   = w_used[SIZE_W-1:1];
  end

  logic accept;
  logic busy_r;
  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // write and read control ride along the arithmetic stages
  logic  rd_v_r   [PIPE_DEPTH];
  logic  wr_v_r   [PIPE_DEPTH];
  addr_t wr_addr_r[PIPE_DEPTH];
  pix_t  wr_pix_r [PIPE_DEPTH];

  logic  wr_ok;
  addr_t wr_addr;
  assign wr_ok   = (13'(in_row) < 13'(MAX_ROWS)) && (13'(in_col) < 13'(MAX_COLS));
  assign wr_addr = AW'(int'(in_row) * MAX_COLS + int'(in_col));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        rd_v_r[i] <= 1'b0;
        wr_v_r[i] <= 1'b0;
      end
    end else begin
      rd_v_r[0] <= accept && (in_mode == MODE_READ);
      wr_v_r[0] <= accept && (in_mode == MODE_WRITE) && wr_ok;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        rd_v_r[i] <= rd_v_r[i-1];
        wr_v_r[i] <= wr_v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r[0] <= wr_addr;
    wr_pix_r[0]  <= in_pixel_in;
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      wr_addr_r[i] <= wr_addr_r[i-1];
      wr_pix_r[i]  <= wr_pix_r[i-1];
    end
  end

  // stage 1: offsets from the centre
  logic signed [9:0] di1_r, dj1_r;
  always_ff @(posedge clk) begin
    di1_r <= $signed({1'b0, in_row}) - $signed({1'b0, ch});
    dj1_r <= $signed({1'b0, in_col}) - $signed({1'b0, cw});
  end

  // stage 2: squares
  logic signed [9:0] di2_r, dj2_r;
  logic [17:0]       sqi_r, sqj_r;
  logic signed [19:0] sqi_full, sqj_full;
  assign sqi_full = di1_r * di1_r;
  assign sqj_full = dj1_r * dj1_r;
  always_ff @(posedge clk) begin
    di2_r <= di1_r;
    dj2_r <= dj1_r;
    sqi_r <= sqi_full[17:0];
    sqj_r <= sqj_full[17:0];
  end

  // stage 3: d2 * inv_norm_sq
  logic signed [9:0] di3_r, dj3_r;
  logic [18:0]       d2;
  logic [34:0]       p_r;
  assign d2 = 19'(sqi_r) + 19'(sqj_r);
  always_ff @(posedge clk) begin
    di3_r <= di2_r;
    dj3_r <= dj2_r;
    p_r   <= 35'(d2) * 35'(invn_r);
  end

  // stage 4: fourth power of r and k1 term
  logic signed [9:0]  di4_r, dj4_r;
  logic [18:0]        rq;
  logic [37:0]        r2p_r;
  logic signed [37:0] t1p_r;
  assign rq = p_r[34:16];
  always_ff @(posedge clk) begin
    di4_r <= di3_r;
    dj4_r <= dj3_r;
    r2p_r <= 38'(rq) * 38'(rq);
    t1p_r <= k1_r * $signed({1'b0, rq});
  end

  // stage 5: k2 term
  logic signed [9:0]  di5_r, dj5_r;
  logic [21:0]        r2q;
  logic signed [40:0] t2p_r;
  logic signed [21:0] t1_r;
  assign r2q = r2p_r[37:16];
  always_ff @(posedge clk) begin
    di5_r <= di4_r;
    dj5_r <= dj4_r;
    t2p_r <= k2_r * $signed({1'b0, r2q});
    t1_r  <= t1p_r[37:16];
  end

  // stage 6: gain in Q16
  logic signed [9:0]  di6_r, dj6_r;
  logic signed [24:0] t2;
  logic signed [26:0] gain_r;
  assign t2 = t2p_r[40:16];
  always_ff @(posedge clk) begin
    di6_r  <= di5_r;
    dj6_r  <= dj5_r;
    gain_r <= 27'sd65536 + 27'(t1_r) + 27'(t2);
  end

  // stage 7: offset times gain
  logic signed [36:0] pri_r, prj_r;
  always_ff @(posedge clk) begin
    pri_r <= di6_r * gain_r;
    prj_r <= dj6_r * gain_r;
  end

  // stage 8: floor, recentre, clamp
  logic signed [21:0] si, sj;
  size_t              sr8, sc8;
  size_t              sr8_r, sc8_r;
  assign si = 22'($signed(pri_r[36:16])) + $signed({13'b0, ch});
  assign sj = 22'($signed(prj_r[36:16])) + $signed({13'b0, cw});

  always_comb begin
    if (si[21]) begin
      sr8 = '0;
    end else if (si > $signed({12'b0, h_m1})) begin
      sr8 = h_m1;
    end else begin
      sr8 = si[SIZE_W-1:0];
    end
    if (sj[21]) begin
      sc8 = '0;
    end else if (sj > $signed({12'b0, w_m1})) begin
      sc8 = w_m1;
    end else begin
      sc8 = sj[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    sr8_r <= sr8;
    sc8_r <= sc8;
  end

  // frame memory, one port shared by writes and reads in request order
  pix_t  frame_mem [DEPTH];
  addr_t rd_addr, mem_addr;
  logic  mem_we;
  pix_t  mem_q_r;
  coord_t src_row_r, src_col_r;
  logic  out_valid_r;

  assign rd_addr  = AW'(int'(sr8_r) * MAX_COLS + int'(sc8_r));
  assign mem_we   = wr_v_r[PIPE_DEPTH-1];
  assign mem_addr = mem_we ? wr_addr_r[PIPE_DEPTH-1] : rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_addr] <= wr_pix_r[PIPE_DEPTH-1];
    end
    mem_q_r   <= frame_mem[mem_addr];
    src_row_r <= sr8_r[COORD_W-1:0];
    src_col_r <= sc8_r[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rd_v_r[PIPE_DEPTH-1];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = mem_q_r;
  assign out_src_row   = src_row_r;
  assign out_src_col   = src_col_r;

endmodule

`default_nettype wire
